// ===== hdl/rmad_pkg.sv =====
// rmad_pkg: shared types, widths and codes for the running median block.
// No dependencies; used by every module under hdl/.
`default_nettype none

package rmad_pkg;

	localparam int CAPACITY  = 256;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int VAL_W     = 32;
	localparam int SUM_W     = 48;
	localparam int COST_W    = 40;
	localparam int CNT_OUT_W = 9;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;
	localparam int MDATA_W   = ((CNT_OUT_W + 2 * VAL_W + COST_W + 7) / 8) * 8;
	localparam int MDATA_PAD = MDATA_W - (CNT_OUT_W + 2 * VAL_W + COST_W);

	// bit offsets inside m_tdata
	localparam int MLO_LSB  = CNT_OUT_W;
	localparam int MHI_LSB  = MLO_LSB + VAL_W;
	localparam int COST_LSB = MHI_LSB + VAL_W;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SEL,
		ST_SUM
	} fsm_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		val_t val;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/rmad_cell.sv =====
// rmad_cell: one slot of the sorted row; compares, shifts and reports rank picks.
// Depends on rmad_pkg.
`default_nettype none

module rmad_cell (
	input  wire logic               clk,
	input  wire rmad_pkg::cnt_t     idx,
	input  wire rmad_pkg::cell_ctl_t ctl,
	input  wire rmad_pkg::cnt_t     count,
	input  wire rmad_pkg::cnt_t     lo_rank,
	input  wire rmad_pkg::cnt_t     hi_rank,
	input  wire rmad_pkg::cnt_t     hm1_rank,
	input  wire logic               left_le,
	input  wire rmad_pkg::val_t     left_val,
	input  wire rmad_pkg::val_t     right_val,
	output rmad_pkg::val_t          val,
	output logic                    le,
	output logic                    eq,
	output logic                    below_ins,
	output logic                    below_del,
	output rmad_pkg::val_t          pick_lo,
	output rmad_pkg::val_t          pick_hi
);
	import rmad_pkg::*;

	val_t val_q;
	logic valid;
	logic lt;

	assign valid = (idx < count);
	assign le    = valid && (val_q <= ctl.val);
	assign lt    = valid && (val_q < ctl.val);
	assign eq    = valid && (val_q == ctl.val);

	// cell at rank hi-1 tells whether the insert/erase point lies in the lower half
	assign below_ins = (idx == hm1_rank) && !le;
	assign below_del = (idx == hm1_rank) && !lt;

	assign pick_lo = (idx == lo_rank) ? val_q : '0;
	assign pick_hi = (idx == hi_rank) ? val_q : '0;
	assign val     = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !le) begin
			val_q <= left_le ? ctl.val : left_val;
		end else if (ctl.del && !lt) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/running_median_abs_deviation_core.sv =====
// running_median_abs_deviation_core: sorted row of compare-and-shift cells with
// running half sums. Depends on rmad_pkg and rmad_cell.
//
//  channel | dir | tdata                 | tuser        | tlast
//  --------+-----+-----------------------+--------------+------
//  s_*     | in  | value                 | action       | -
//  m_*     | out | count,mlo,mhi,cost    | status       | -
//
// Steps per transaction: accept, compare and shift in the cell row, rank pick
// from the row, half-sum update; the sum step waits while an earlier result is
// still held in the output register.
// Reset: arst_n clears count, sums, FSM and output valid; cell contents need no
// clearing since only ranks below the count are ever read.
// Stalls: a new transaction is accepted while the previous result waits.
`default_nettype none

module running_median_abs_deviation_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [rmad_pkg::VAL_W-1:0]     s_tdata,  // [31:0] value
	input  wire logic [rmad_pkg::ACT_W-1:0]     s_tuser,  // [1:0] action
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [rmad_pkg::MDATA_W-1:0]        m_tdata,  // element_count, median_low,
	                                                      // median_high, abs_dev_cost, pad
	output logic [rmad_pkg::STAT_W-1:0]         m_tuser   // [1:0] status
);
	import rmad_pkg::*;

	fsm_t state_q, state_n;

	logic [ACT_W-1:0] action_q;
	val_t             value_q;
	cnt_t             count_q;
	sum_t             lsum_q;   // sum of the smallest count/2 values
	sum_t             tsum_q;   // sum of all values
	logic             ins_q, del_q, below_q, odd_old_q;
	logic [STAT_W-1:0] status_q;
	val_t             mlo_q, mhi_q;

	logic               m_tvalid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [CNT_OUT_W-1:0] out_count_q;
	val_t               out_mlo_q, out_mhi_q;
	logic [COST_W-1:0]  out_cost_q;

	// cell row
	cell_ctl_t          ctl;
	val_t               cval   [CAPACITY];
	val_t               plo    [CAPACITY];
	val_t               phi    [CAPACITY];
	logic [CAPACITY-1:0] le_v, eq_v, bi_v, bd_v;
	cnt_t               lo_rank, hi_rank, hm1_rank;

	logic s_acc, load_out, do_cmp;
	logic found, do_ins, do_del;
	val_t mlo_n, mhi_n;

	assign s_acc    = s_tvalid && s_tready;
	assign lo_rank  = (count_q - cnt_t'(1)) >> 1;
	assign hi_rank  = count_q >> 1;
	assign hm1_rank = hi_rank - cnt_t'(1);  // wraps past any index when hi is 0

	assign found  = |eq_v;
	assign do_ins = (action_q == ACT_INSERT) && (count_q < cnt_t'(CAPACITY));
	assign do_del = (action_q == ACT_ERASE) && found;

	assign ctl.ins = do_cmp && do_ins;
	assign ctl.del = do_cmp && do_del;
	assign ctl.val = value_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic lle;
		val_t lval, rval;
		if (i == 0) begin : g_first
			assign lle  = 1'b1;
			assign lval = '0;
		end else begin : g_mid
			assign lle  = le_v[i-1];
			assign lval = cval[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rval = cval[i];
		end else begin : g_inner
			assign rval = cval[i+1];
		end
		rmad_cell u_cell (
			.clk       (clk),
			.idx       (cnt_t'(i)),
			.ctl       (ctl),
			.count     (count_q),
			.lo_rank   (lo_rank),
			.hi_rank   (hi_rank),
			.hm1_rank  (hm1_rank),
			.left_le   (lle),
			.left_val  (lval),
			.right_val (rval),
			.val       (cval[i]),
			.le        (le_v[i]),
			.eq        (eq_v[i]),
			.below_ins (bi_v[i]),
			.below_del (bd_v[i]),
			.pick_lo   (plo[i]),
			.pick_hi   (phi[i])
		);
	end

	// one-hot picks from the row, OR-combined
	always_comb begin
		mlo_n = '0;
		mhi_n = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			mlo_n = mlo_n | plo[i];
			mhi_n = mhi_n | phi[i];
		end
	end

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		s_tready = 1'b0;
		do_cmp   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_n = ST_CMP;
				end
			end
			ST_CMP: begin
				do_cmp  = 1'b1;
				state_n = ST_SEL;
			end
			ST_SEL: begin
				state_n = ST_SUM;
			end
			ST_SUM: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_acc) begin
			action_q <= s_tuser;
			value_q  <= s_tdata;
		end
	end

	// compare step flags, rank picks
	always_ff @(posedge clk) begin
		if (do_cmp) begin
			ins_q     <= do_ins;
			del_q     <= do_del;
			odd_old_q <= count_q[0];
			below_q   <= do_ins ? (|bi_v) : (|bd_v);
			case (action_q)
				ACT_INSERT: status_q <= do_ins ? STAT_DONE : STAT_FULL;
				ACT_ERASE:  status_q <= found ? STAT_DONE : STAT_ABSENT;
				default:    status_q <= STAT_DONE;
			endcase
		end
		if (state_q == ST_SEL) begin
			mlo_q <= (count_q == '0) ? val_t'(0) : mlo_n;
			mhi_q <= (count_q == '0) ? val_t'(0) : mhi_n;
		end
	end

	// half-sum update: cost = upper_sum - lower_sum, the median terms cancel
	sum_t lsum_n, tsum_n, diff;
	sum_t m48, v48;
	logic [COST_W-1:0] cost_n;

	assign m48 = sum_t'(mlo_q);
	assign v48 = sum_t'(value_q);

	always_comb begin
		lsum_n = lsum_q;
		tsum_n = tsum_q;
		if (ins_q) begin
			tsum_n = tsum_q + v48;
			lsum_n = lsum_q + (below_q ? (v48 - m48) : sum_t'(0))
			       + (odd_old_q ? m48 : sum_t'(0));
		end else if (del_q) begin
			tsum_n = tsum_q - v48;
			lsum_n = lsum_q + (below_q ? (m48 - v48) : sum_t'(0))
			       - (odd_old_q ? sum_t'(0) : m48);
		end
		diff = tsum_n - (lsum_n <<< 1) - (count_q[0] ? m48 : sum_t'(0));
		if (diff < 0) begin
			cost_n = '0;
		end else if (diff > sum_t'({1'b0, COST_MAX})) begin
			cost_n = COST_MAX;
		end else begin
			cost_n = diff[COST_W-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			lsum_q     <= '0;
			tsum_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (do_cmp) begin
				if (do_ins) begin
					count_q <= count_q + cnt_t'(1);
				end else if (do_del) begin
					count_q <= count_q - cnt_t'(1);
				end
			end
			if (load_out) begin
				lsum_q     <= lsum_n;
				tsum_q     <= tsum_n;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_count_q  <= CNT_OUT_W'(count_q);
			out_mlo_q    <= mlo_q;
			out_mhi_q    <= mhi_q;
			out_cost_q   <= cost_n;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{MDATA_PAD{1'b0}}, out_cost_q, out_mhi_q, out_mlo_q, out_count_q};

endmodule

`default_nettype wire

// ===== hdl/rmad_checker.sv =====
// rmad_checker: port-level assertions for the running median core, plus bind.
// Depends on rmad_pkg and running_median_abs_deviation_core.
`default_nettype none

module rmad_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [rmad_pkg::MDATA_W-1:0] m_tdata,
	input wire logic [rmad_pkg::STAT_W-1:0]  m_tuser
);
	import rmad_pkg::*;

	logic [CNT_OUT_W-1:0] cnt;
	val_t                 mlo, mhi;

	assign cnt       = m_tdata[CNT_OUT_W-1:0];
	assign mlo       = m_tdata[MLO_LSB +: VAL_W];
	assign mhi       = m_tdata[MHI_LSB +: VAL_W];

	// the core works on one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on back-to-back cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_FULL |-> cnt == CNT_OUT_W'(CAPACITY))
		else $error("full status with store not full");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cnt == '0 |-> m_tdata[MDATA_W-1:MLO_LSB] == '0)
		else $error("empty set reports nonzero median or cost");

	a_median_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> mlo <= mhi)
		else $error("lower median above upper median");

endmodule

bind running_median_abs_deviation_core rmad_checker u_rmad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
